// File: hw/rtl/positional_list_insert_delete_macros.svh
// ----------------------------------------------------------------------------
// positional list assertion macros
// shared property forms for the checker of the positional list block
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_MACROS_SVH

// same-cycle implication, checked outside reset
`define PLID_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define PLID_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/plid_pkg.sv
// ----------------------------------------------------------------------------
// plid_pkg
// types, codes and sizes shared by the positional list block
// ----------------------------------------------------------------------------
package plid_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int POS_W    = 5;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	// operation codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         op;
		logic [POS_W-1:0]   position;
		logic signed [31:0] value;
	} plid_req_t;

	typedef struct packed {
		logic signed [31:0] element;
		logic               element_valid;
		logic               last;
		logic [1:0]         status;
	} plid_rsp_t;

	typedef enum logic {
		S_IDLE,
		S_READ
	} plid_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic rd_step;
	} plid_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic start_read;
		logic rd_last;
	} plid_sts_t;

endpackage

// File: hw/rtl/positional_list_insert_delete.sv
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// ordered list of signed 32-bit values with positional insert and delete
// ----------------------------------------------------------------------------
// usage
//   cmd channel (cmd_valid, cmd_stall, cmd) carries op, position and value;
//   a transfer happens at a clock edge with cmd_valid high and cmd_stall low
//   res channel (res_valid, res_stall, res) returns element, element_valid,
//   last and status, one result per transfer
//   insert and delete: one result, registered, seen in the cycle after the
//   command transfer; a new command can be taken every unstalled cycle
//   read-out: one result per element, each loaded into the res register
//   by one read step of the sequencer in S_READ;
//   the block takes no command until the last element is in the res register
//   an empty read-out gives one result with no element; op code 3 gives none
//   the single res register sets the pace: while res_stall holds a result,
//   cmd_stall is high and read-out pauses, nothing is lost or repeated
//   reset clears the element count and the sequencer; cells need no clearing
//   since only cells below the count are ever read
// ----------------------------------------------------------------------------
module positional_list_insert_delete import plid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  plid_req_t cmd,
	output logic      res_valid,
	input  logic      res_stall,
	output plid_rsp_t res
);

	// command and status between sequencer and datapath
	plid_ctl_t ctl;
	plid_sts_t sts;

	// sequencer: takes commands and steps a read-out one element at a time
	plid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// datapath: cells shift in parallel on insert or delete, result register
	plid_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.res_stall (res_stall),
		.res       (res),
		.res_valid (res_valid),
		.sts       (sts)
	);

endmodule

// File: hw/rtl/plid_ctrl.sv
// ----------------------------------------------------------------------------
// plid_ctrl
// sequencer for command acceptance and list read-out
// ----------------------------------------------------------------------------
module plid_ctrl import plid_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  plid_sts_t   sts,
	output plid_ctl_t   ctl
);

	plid_state_t state_q;
	plid_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ctl.accept  = 1'b0;
		ctl.rd_step = 1'b0;
		cmd_stall   = 1'b1;
		case (state_q)
			S_IDLE: begin
				cmd_stall  = !sts.out_free;
				ctl.accept = cmd_valid && sts.out_free;
				if (ctl.accept && sts.start_read) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				ctl.rd_step = sts.out_free;
				if (sts.out_free && sts.rd_last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: hw/rtl/plid_dp.sv
// ----------------------------------------------------------------------------
// plid_dp
// element cells, count, read index and result register
// ----------------------------------------------------------------------------
module plid_dp import plid_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  plid_req_t  cmd,
	input  plid_ctl_t  ctl,
	input  logic       res_stall,
	output plid_rsp_t  res,
	output logic       res_valid,
	output plid_sts_t  sts
);

	logic signed [31:0] cells_q [CAPACITY];
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	plid_rsp_t          res_q;
	logic               res_valid_q;

	logic [POS_W-1:0] ins_slot;
	logic [POS_W-1:0] del_slot;
	logic [CMP_W-1:0] ins_slot_w;
	logic [CMP_W-1:0] del_slot_w;
	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] cnt_w;
	logic             full;
	logic             ins_ok;
	logic             del_ok;
	logic             do_ins;
	logic             do_del;
	logic             emit;
	plid_rsp_t        rsp_d;

	assign ins_slot   = (cmd.position == '0) ? '0 : cmd.position - POS_W'(1);
	assign del_slot   = cmd.position - POS_W'(1);
	assign ins_slot_w = CMP_W'(ins_slot);
	assign del_slot_w = CMP_W'(del_slot);
	assign pos_w      = CMP_W'(cmd.position);
	assign cnt_w      = CMP_W'(count_q);

	assign full   = (count_q == CNT_W'(CAPACITY));
	assign ins_ok = !full && (ins_slot_w <= cnt_w);
	assign del_ok = (count_q != '0) && (cmd.position != '0) && (pos_w <= cnt_w);
	assign do_ins = ctl.accept && (cmd.op == OP_INSERT) && ins_ok;
	assign do_del = ctl.accept && (cmd.op == OP_DELETE) && del_ok;

	assign sts.out_free   = !res_valid_q || !res_stall;
	assign sts.start_read = (cmd.op == OP_READ) && (count_q != '0);
	assign sts.rd_last    = (CNT_W'(idx_q) == count_q - CNT_W'(1));

	// result selection: one status word per insert, delete or empty read, one element per read step
	always_comb begin
		emit                = 1'b0;
		rsp_d.element       = '0;
		rsp_d.element_valid = 1'b0;
		rsp_d.last          = 1'b1;
		rsp_d.status        = STAT_DONE;
		if (ctl.rd_step) begin
			emit                = 1'b1;
			rsp_d.element       = cells_q[idx_q];
			rsp_d.element_valid = 1'b1;
			rsp_d.last          = sts.rd_last;
		end else if (ctl.accept) begin
			case (cmd.op)
				OP_INSERT: begin
					emit = 1'b1;
					if (full) begin
						rsp_d.status = STAT_FULL;
					end else if (!ins_ok) begin
						rsp_d.status = STAT_RANGE;
					end
				end
				OP_DELETE: begin
					emit = 1'b1;
					if (!del_ok) begin
						rsp_d.status = STAT_RANGE;
					end
				end
				OP_READ: begin
					emit = (count_q == '0);
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	// each cell picks its own neighbor, so all cells shift in parallel
	always_ff @(posedge clk) begin
		for (int k = 0; k < CAPACITY; k++) begin
			if (do_ins) begin
				if (CMP_W'(k) == ins_slot_w) begin
					cells_q[IDX_W'(k)] <= cmd.value;
				end else if ((k > 0) && (CMP_W'(k) > ins_slot_w)) begin
					cells_q[IDX_W'(k)] <= cells_q[IDX_W'((k > 0) ? k - 1 : 0)];
				end
			end else if (do_del) begin
				if ((k < CAPACITY - 1) && (CMP_W'(k) >= del_slot_w)) begin
					cells_q[IDX_W'(k)] <= cells_q[IDX_W'((k < CAPACITY - 1) ? k + 1 : k)];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (do_ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_del) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (ctl.accept && sts.start_read) begin
				idx_q <= '0;
			end else if (ctl.rd_step) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= rsp_d;
		end
	end

	assign res       = res_q;
	assign res_valid = res_valid_q;

endmodule

// File: hw/rtl/plid_checker.sv
// ----------------------------------------------------------------------------
// plid_checker
// port-level properties of the positional list block
// ----------------------------------------------------------------------------
`include "positional_list_insert_delete_macros.svh"

module plid_checker import plid_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      cmd_valid,
	input logic      cmd_stall,
	input plid_req_t cmd,
	input logic      res_valid,
	input logic      res_stall,
	input plid_rsp_t res
);

	`PLID_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "stalled result changed")
	`PLID_ASSERT_NOW(a_mid_is_elem, res_valid && !res.last, res.element_valid, "non-final result without element")
	`PLID_ASSERT_NOW(a_no_elem_zero, res_valid && !res.element_valid, res.element == '0, "element not zero without entry")
	`PLID_ASSERT_NOW(a_elem_done, res_valid && res.element_valid, res.status == STAT_DONE, "element with bad status")
	`PLID_ASSERT_NEXT(a_edit_result, cmd_valid && !cmd_stall && (cmd.op == OP_INSERT || cmd.op == OP_DELETE), res_valid && res.last && !res.element_valid, "edit command gave no result")

endmodule

bind positional_list_insert_delete plid_checker u_plid_checker (.*);
